// ===== design/rc5_block_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// rc5 block cipher assertion macros
// concurrent checks on a clock with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef RC5_BLOCK_CIPHER_ASSERT_SVH
`define RC5_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTH

`define RC5_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc5 check failed: same-cycle implication");

`define RC5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc5 check failed: next-cycle implication");

`else

`define RC5_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define RC5_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/rc5_pkg.sv =====
// ----------------------------------------------------------------------------
// rc5 package
// request and result types, cipher constants, sequencer states
// ----------------------------------------------------------------------------
package rc5_pkg;

  localparam logic [31:0] P32       = 32'hb7e15163;
  localparam logic [31:0] Q32       = 32'h9e3779b9;
  localparam int          KEY_WORDS = 4;
  localparam int          KW_BITS   = 2;

  typedef struct packed {
    logic        op;
    logic [31:0] data_lo;
    logic [31:0] data_hi;
  } rc5_in_t;

  typedef struct packed {
    logic [31:0] out_lo;
    logic [31:0] out_hi;
  } rc5_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_A,
    ST_MIX_B,
    ST_CRYPT
  } rc5_state_t;

  // operation codes of the request
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

// ===== design/rc5_block_cipher.sv =====
// ----------------------------------------------------------------------------
// rc5 block cipher
// rc5-32 with a 16-byte key, lazy key schedule and an iterative datapath
// ----------------------------------------------------------------------------
//  channel   ports                               direction  transfer
//  request   start, busy, in_data                in         start && !busy
//  result    out_valid, out_data                 out        one-cycle strobe
//  config    psel penable pwrite paddr pwdata    in/out     apb write, pready=1
//
//  a block steps through all T = 2*ROUNDS+2 round keys (26 at 12 rounds): one half-round per
//  cycle through the shared add/rotate unit, paced by the single read port
//  of the round-key memory. the result strobe follows in the next cycle.
//  after reset or a key write the first request first runs the key schedule:
//  table init of T words, then 3*T mixing steps, each a mix_a and a mix_b state.
//  rst_n is synchronous; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "rc5_block_cipher_assert.svh"

module rc5_block_cipher #(
  parameter int ROUNDS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rc5_pkg::rc5_in_t in_data,
  output logic             out_valid,
  output rc5_pkg::rc5_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rc5_pkg::*;

  localparam int T  = 2 * (ROUNDS + 1);
  localparam int AW = $clog2(T);
  localparam int SW = $clog2(3 * T);

  localparam logic [AW-1:0] K_LAST = AW'(T - 1);
  localparam logic [SW-1:0] S_LAST = SW'(3 * T - 1);

  rc5_state_t state_r, state_nxt;

  logic [31:0] key_r     [KEY_WORDS];
  logic [31:0] key_nxt   [KEY_WORDS];
  logic [31:0] scratch_r [KEY_WORDS];
  logic [31:0] scratch_nxt [KEY_WORDS];
  logic        keys_ready_r, keys_ready_nxt;

  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] blk_a_r, blk_a_nxt, blk_b_r, blk_b_nxt;
  logic        op_r, op_nxt;
  logic [AW-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [KW_BITS-1:0] j_r, j_nxt;
  logic        out_valid_r, out_valid_nxt;

  // round-key memory
  logic [31:0]   rk_mem [T];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  // shared add / rotate / add-xor unit
  logic [31:0] u_p0, u_p1, u_p2, u_q, u_r, u_sum, u_res;
  logic [4:0]  u_amt;

  logic accept, cfg_wr, init_last, mix_last, crypt_last, k_low;
  logic [AW-1:0] k_first;

  assign accept     = start && !busy;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign init_last  = (i_r == K_LAST);
  assign mix_last   = (step_r == S_LAST);
  assign crypt_last = (op_r == OP_DECRYPT) ? (k_r == '0) : (k_r == K_LAST);
  assign k_low      = (k_r[AW-1:1] == '0);
  assign k_first    = (in_data.op == OP_DECRYPT) ? K_LAST : '0;

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_data.out_lo = blk_a_r;
  assign out_data.out_hi = blk_b_r;
  assign pready          = 1'b1;
  assign prdata          = key_r[paddr[3:2]];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rk_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= rk_mem[rd_addr];
  end

  // shared unit operand select
  always_comb begin
    u_p0  = '0;
    u_p1  = '0;
    u_p2  = '0;
    u_amt = '0;
    u_q   = '0;
    u_r   = '0;
    unique case (state_r)
      ST_INIT: begin
        u_p0 = a_r;
        u_p1 = Q32;
      end
      ST_MIX_A: begin
        u_p0  = rd_data_r;
        u_p1  = a_r;
        u_p2  = b_r;
        u_amt = 5'd3;
      end
      ST_MIX_B: begin
        u_p0  = scratch_r[j_r];
        u_p1  = a_r;
        u_p2  = b_r;
        u_amt = a_r[4:0] + b_r[4:0];
      end
      ST_CRYPT: begin
        if (op_r == OP_ENCRYPT) begin
          if (k_low) begin
            // pre-whitening
            u_p0 = k_r[0] ? blk_b_r : blk_a_r;
            u_p1 = rd_data_r;
          end else begin
            u_p0  = blk_a_r ^ blk_b_r;
            u_amt = k_r[0] ? blk_a_r[4:0] : blk_b_r[4:0];
            u_q   = rd_data_r;
          end
        end else begin
          // subtract via inverted operand plus one, right rotate as left by -s
          u_p0 = k_r[0] ? blk_b_r : blk_a_r;
          u_p1 = ~rd_data_r;
          u_p2 = 32'd1;
          if (!k_low) begin
            u_amt = k_r[0] ? (5'd0 - blk_a_r[4:0]) : (5'd0 - blk_b_r[4:0]);
            u_r   = k_r[0] ? blk_a_r : blk_b_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign u_sum = u_p0 + u_p1 + u_p2;
  assign u_res = (rotl32(u_sum, u_amt) + u_q) ^ u_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = keys_ready_r ? ST_CRYPT : ST_INIT;
        end
      end
      ST_INIT: begin
        if (init_last) begin
          state_nxt = ST_MIX_A;
        end
      end
      ST_MIX_A: state_nxt = ST_MIX_B;
      ST_MIX_B: state_nxt = mix_last ? ST_CRYPT : ST_MIX_A;
      ST_CRYPT: begin
        if (crypt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and counter updates
  always_comb begin
    key_nxt        = key_r;
    scratch_nxt    = scratch_r;
    keys_ready_nxt = keys_ready_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    blk_a_nxt      = blk_a_r;
    blk_b_nxt      = blk_b_r;
    op_nxt         = op_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    step_nxt       = step_r;
    j_nxt          = j_r;
    out_valid_nxt  = 1'b0;
    rd_addr        = k_r;
    wr_en          = 1'b0;
    wr_addr        = i_r;
    wr_data        = u_res;

    if (cfg_wr) begin
      key_nxt[paddr[3:2]] = pwdata;
      keys_ready_nxt      = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.op;
          blk_a_nxt = in_data.data_lo;
          blk_b_nxt = in_data.data_hi;
          k_nxt     = k_first;
          rd_addr   = k_first;
          if (!keys_ready_r) begin
            scratch_nxt = key_r;
            a_nxt       = P32;
            i_nxt       = '0;
          end
        end
      end
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = a_r;
        a_nxt   = u_res;
        i_nxt   = i_r + 1'b1;
        rd_addr = '0;
        if (init_last) begin
          a_nxt    = '0;
          b_nxt    = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          step_nxt = '0;
        end
      end
      ST_MIX_A: begin
        wr_en = 1'b1;
        a_nxt = u_res;
      end
      ST_MIX_B: begin
        b_nxt              = u_res;
        scratch_nxt[j_r]   = u_res;
        j_nxt              = j_r + 1'b1;
        i_nxt              = (i_r == K_LAST) ? '0 : i_r + 1'b1;
        step_nxt           = step_r + 1'b1;
        rd_addr            = i_nxt;
        if (mix_last) begin
          keys_ready_nxt = 1'b1;
          rd_addr        = k_r;
        end
      end
      ST_CRYPT: begin
        if (k_r[0]) begin
          blk_b_nxt = u_res;
        end else begin
          blk_a_nxt = u_res;
        end
        k_nxt   = (op_r == OP_DECRYPT) ? k_r - 1'b1 : k_r + 1'b1;
        rd_addr = k_nxt;
        if (crypt_last) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      key_r        <= '{default: '0};
    end else begin
      state_r      <= state_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      key_r        <= key_nxt;
    end
    scratch_r <= scratch_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    blk_a_r   <= blk_a_nxt;
    blk_b_r   <= blk_b_nxt;
    op_r      <= op_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    step_r    <= step_nxt;
    j_r       <= j_nxt;
  end

  `RC5_ASSERT_SAME(a_res_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `RC5_ASSERT_SAME(a_crypt_keys, clk, rst_n, state_r == ST_CRYPT, keys_ready_r)
  `RC5_ASSERT_SAME(a_init_stale, clk, rst_n, state_r == ST_INIT, !keys_ready_r)
  `RC5_ASSERT_NEXT(a_req_busy, clk, rst_n, accept, busy && !out_valid_r)

endmodule

// ===== sim/tb_rc5_block_cipher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc5 block cipher testbench
// drives encrypt and decrypt requests under several keys and checks every
// result strobe against a cycle-free model of rc5-32 kept in the bench
// ----------------------------------------------------------------------------
module tb_rc5_block_cipher;
  import rc5_pkg::*;

  localparam int ROUNDS          = 12;
  localparam int SCHED_WORDS     = 2 * (ROUNDS + 1);
  localparam int BLOCK_CYCLES    = 2 * ROUNDS + 2;
  localparam int KEY_ADDR_STEP   = 4;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_REQUESTS  = 200;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rc5_in_t     in_data;
  logic        out_valid;
  rc5_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the key registers and the expanded round-key table
  logic [31:0] key_model [KEY_WORDS];
  logic [31:0] sched [SCHED_WORDS];
  bit          sched_ready;

  rc5_out_t    expected_blocks [$];
  rc5_out_t    head_block;

  int fail_count;
  int checked_count;
  int encrypt_count;
  int decrypt_count;
  int key_writes;

  rc5_block_cipher #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] rotate_left(logic [31:0] x, logic [31:0] s);
    logic [4:0] amt;
    amt = s[4:0];
    if (amt == 5'd0) return x;
    return (x << amt) | (x >> (6'd32 - amt));
  endfunction

  function automatic logic [31:0] rotate_right(logic [31:0] x, logic [31:0] s);
    logic [4:0] amt;
    amt = s[4:0];
    if (amt == 5'd0) return x;
    return (x >> amt) | (x << (6'd32 - amt));
  endfunction

  function automatic void expand_schedule();
    logic [31:0] mix_key [KEY_WORDS];
    logic [31:0] a;
    logic [31:0] b;
    int          i;
    int          j;
    for (int n = 0; n < KEY_WORDS; n++) mix_key[n] = key_model[n];
    sched[0] = P32;
    for (int n = 1; n < SCHED_WORDS; n++) sched[n] = sched[n-1] + Q32;
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    for (int n = 0; n < 3 * SCHED_WORDS; n++) begin
      a = rotate_left(sched[i] + a + b, 32'd3);
      sched[i] = a;
      b = rotate_left(mix_key[j] + a + b, a + b);
      mix_key[j] = b;
      i = (i + 1 == SCHED_WORDS) ? 0 : i + 1;
      j = (j + 1) % KEY_WORDS;
    end
    sched_ready = 1'b1;
  endfunction

  function automatic rc5_out_t rc5_transform(rc5_in_t req);
    logic [31:0] a;
    logic [31:0] b;
    rc5_out_t    res;
    if (!sched_ready) expand_schedule();
    a = req.data_lo;
    b = req.data_hi;
    if (req.op == OP_ENCRYPT) begin
      a = a + sched[0];
      b = b + sched[1];
      for (int r = 1; r <= ROUNDS; r++) begin
        a = rotate_left(a ^ b, b) + sched[2*r];
        b = rotate_left(b ^ a, a) + sched[2*r+1];
      end
    end else begin
      for (int r = ROUNDS; r > 0; r--) begin
        b = rotate_right(b - sched[2*r+1], a) ^ a;
        a = rotate_right(a - sched[2*r], b) ^ b;
      end
      b = b - sched[1];
      a = a - sched[0];
    end
    res.out_lo = a;
    res.out_hi = b;
    return res;
  endfunction

  // -------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        $error("result strobe with no request outstanding: out_lo=%h out_hi=%h",
               out_data.out_lo, out_data.out_hi);
        fail_count++;
      end else begin
        head_block = expected_blocks.pop_front();
        checked_count++;
        if (out_data.out_lo !== head_block.out_lo) begin
          $error("out_lo mismatch: expected %h, actual %h", head_block.out_lo,
                 out_data.out_lo);
          fail_count++;
        end
        if (out_data.out_hi !== head_block.out_hi) begin
          $error("out_hi mismatch: expected %h, actual %h", head_block.out_hi,
                 out_data.out_hi);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------- driver

  task automatic push_request(logic op, logic [31:0] lo, logic [31:0] hi);
    rc5_in_t req;
    req.op      = op;
    req.data_lo = lo;
    req.data_hi = hi;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    expected_blocks.push_back(rc5_transform(req));
    if (op == OP_ENCRYPT) encrypt_count++;
    else decrypt_count++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // block is idle once every result is in and busy has dropped
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write one key word, then read it back
  task automatic load_key(int idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * KEY_ADDR_STEP);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_model[idx] = value;
    sched_ready    = 1'b0;
    key_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== key_model[idx]) begin
      $error("key_word%0d readback mismatch: expected %h, actual %h", idx,
             key_model[idx], prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                         logic [31:0] k3);
    load_key(0, k0);
    load_key(1, k1);
    load_key(2, k2);
    load_key(3, k3);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // zero key straight out of reset, schedule built on the first request
  task automatic test_reset_key();
    push_request(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    push_request(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    push_request(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_request(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_request(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
    push_request(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
    push_request(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    settle();
  endtask

  // data picked so that the first rotate amount is a multiple of 32
  task automatic test_rotate_zero();
    if (!sched_ready) expand_schedule();
    push_request(OP_ENCRYPT, $urandom, 32'h0 - sched[1]);
    push_request(OP_DECRYPT, 32'h1234_5660, $urandom);
    push_request(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    settle();
  endtask

  task automatic test_key_extremes();
    set_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_request(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    push_request(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_request(OP_ENCRYPT, 32'hdead_beef, 32'h0bad_f00d);
    settle();
    set_key(32'h5555_aaaa, 32'haaaa_5555, 32'h0123_4567, 32'h89ab_cdef);
    push_request(OP_DECRYPT, 32'h0000_0000, 32'hffff_ffff);
    push_request(OP_ENCRYPT, 32'hffff_ffff, 32'h0000_0000);
    push_request(OP_DECRYPT, 32'h7fff_ffff, 32'h8000_0000);
    settle();
  endtask

  // rewriting a word with its own value still forces a fresh schedule
  task automatic test_key_rewrite();
    load_key(2, key_model[2]);
    push_request(OP_ENCRYPT, $urandom, $urandom);
    push_request(OP_DECRYPT, $urandom, $urandom);
    settle();
    load_key(0, $urandom);
    push_request(OP_DECRYPT, $urandom, $urandom);
    push_request(OP_ENCRYPT, $urandom, $urandom);
    settle();
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int gap;
    bit paused;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase % 3 == 2) begin
        load_key($urandom_range(0, KEY_WORDS - 1), random_word());
      end else begin
        set_key(random_word(), random_word(), random_word(), random_word());
      end
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_REQUESTS) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < PHASE_REQUESTS; k++) begin
          push_request(1'($urandom_range(0, 1)), random_word(), random_word());
          sent++;
        end
        idle_cycles(gap);
        // hold the next request until the pipe has fully emptied
        if (!paused && sent >= PHASE_REQUESTS / 2) begin
          idle_cycles(1);
          wait_drained();
          paused = 1'b1;
        end
      end
      settle();
    end
  endtask

  // ----------------------------------------------------------------- main

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    for (int n = 0; n < KEY_WORDS; n++) key_model[n] = '0;
    for (int n = 0; n < SCHED_WORDS; n++) sched[n] = '0;
    sched_ready   = 1'b0;
    fail_count    = 0;
    checked_count = 0;
    encrypt_count = 0;
    decrypt_count = 0;
    key_writes    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_rotate_zero();
    test_key_extremes();
    test_key_rewrite();
    test_random_traffic();

    settle();
    repeat (2 * BLOCK_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d encrypt and %0d decrypt requests",
             checked_count, encrypt_count, decrypt_count);
    $display("key words written and read back %0d times, incl. all-zero and all-one keys",
             key_writes);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", expected_blocks.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rc5_pkg.sv
design/rc5_block_cipher.sv
sim/tb_rc5_block_cipher.sv
